### sv/rpd_pkg.sv
`default_nettype none
package rpd_pkg;

  localparam int DATA_W = 32;
  localparam int TOP_W  = 11;
  localparam int HEAD_W = 17;
  localparam int DRAW_W = 16;

  // head count of all ones means no limit
  localparam logic [HEAD_W-1:0] HEAD_UNLIMITED = '1;
  localparam logic [DRAW_W-1:0] DRAW_SAT       = '1;

  typedef enum logic [1:0] {
    REG_BASE,
    REG_SPAN,
    REG_HEAD,
    REG_REPEAT
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SLOT
  } state_t;

  typedef struct packed {
    logic clr_restart;
    logic clr_step;
    logic start;
    logic rd_slot;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic active;
    logic div_busy;
    logic out_free;
  } stat_t;

  function automatic logic limit_hit(logic [HEAD_W-1:0] head, logic [DRAW_W-1:0] draws);
    logic hit;
    if (head == HEAD_UNLIMITED) begin
      hit = 1'b0;
    end else if (head[HEAD_W-1]) begin
      hit = 1'b1;
    end else begin
      hit = (draws >= head[DRAW_W-1:0]);
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

### sv/rpd_ram.sv
`default_nettype none
module rpd_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### sv/rpd_div.sv
`default_nettype none
module rpd_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [rpd_pkg::DATA_W-1:0]   dividend,
  input  wire logic [rpd_pkg::TOP_W-1:0]    divisor,
  output logic                              busy,
  output logic      [rpd_pkg::TOP_W-1:0]    rem
);

  localparam int CNT_W = $clog2(rpd_pkg::DATA_W + 1);

  logic [rpd_pkg::DATA_W-1:0] quo_r, quo_nxt;
  logic [rpd_pkg::TOP_W-1:0]  rem_r, rem_nxt;
  logic [rpd_pkg::TOP_W-1:0]  div_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic [rpd_pkg::TOP_W:0]    trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[rpd_pkg::DATA_W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[rpd_pkg::DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = rpd_pkg::TOP_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[rpd_pkg::TOP_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(rpd_pkg::DATA_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

### sv/rpd_ctrl.sv
`default_nettype none
module rpd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rpd_pkg::stat_t stat,
  output rpd_pkg::cmd_t       cmd
);

  rpd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpd_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      rpd_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = rpd_pkg::ST_IDLE;
        end
      end
      rpd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        // a beat taken after the sequence ended simply produces nothing
        if (in_valid && stat.active) begin
          cmd.start = 1'b1;
          state_nxt = rpd_pkg::ST_DIV;
        end
      end
      rpd_pkg::ST_DIV: begin
        if (!stat.div_busy) begin
          cmd.rd_slot = 1'b1;
          state_nxt   = rpd_pkg::ST_SLOT;
        end
      end
      rpd_pkg::ST_SLOT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = rpd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rpd_pkg::ST_CLEAR;
    endcase
    // register write restarts the sequence with a fresh clearing pass
    if (cfg_wr) begin
      cmd       = '0;
      cmd.clr_restart = 1'b1;
      in_stall  = 1'b1;
      state_nxt = rpd_pkg::ST_CLEAR;
    end
  end

endmodule
`default_nettype wire

### sv/rpd_dp.sv
`default_nettype none
module rpd_dp #(
  parameter int MAX_SPAN = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rpd_pkg::cmd_t                cmd,
  output rpd_pkg::stat_t                    stat,
  input  wire logic [rpd_pkg::DATA_W-1:0]   base_value,
  input  wire logic [rpd_pkg::TOP_W-1:0]    span_count,
  input  wire logic [rpd_pkg::HEAD_W-1:0]   head_count,
  input  wire logic                         repeat_mode,
  input  wire logic [rpd_pkg::DATA_W-1:0]   random_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [rpd_pkg::DATA_W-1:0]   out_drawn_value,
  output logic                              out_last
);

  localparam int SW = $clog2(MAX_SPAN);
  localparam logic [SW-1:0] CLR_LAST = SW'(MAX_SPAN - 1);

  logic [rpd_pkg::TOP_W-1:0]  top_r, top_nxt, eff_span, top_dec;
  logic [rpd_pkg::DRAW_W-1:0] draws_r, draws_nxt;
  logic [SW-1:0]              clr_cnt_r;
  logic                       start_q_r;
  logic [SW-1:0]              top_content_r;
  logic                       out_valid_r;
  logic [rpd_pkg::DATA_W-1:0] out_drawn_r;
  logic                       out_last_r;

  logic                       div_busy;
  logic [rpd_pkg::TOP_W-1:0]  slot;
  logic [SW:0]                rd_data;
  logic [SW-1:0]              slot_content;
  logic                       ram_wr_en, ram_rd_en;
  logic [SW-1:0]              ram_wr_addr, ram_rd_addr;
  logic [SW:0]                ram_wr_data;

  assign eff_span = (32'(span_count) > 32'(MAX_SPAN)) ?
                    rpd_pkg::TOP_W'(MAX_SPAN) : span_count;
  assign top_dec  = top_r - 1'b1;

  rpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (random_value),
    .divisor  (top_r),
    .busy     (div_busy),
    .rem      (slot)
  );

  // entry: {valid, mapped slot}; a cleared entry maps to itself
  rpd_ram #(
    .WIDTH (SW + 1),
    .DEPTH (MAX_SPAN)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = clr_cnt_r;
    ram_wr_data = '0;
    if (cmd.clr_step) begin
      ram_wr_en = 1'b1;
    end else if (cmd.commit && !repeat_mode) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = SW'(slot);
      ram_wr_data = {1'b1, top_content_r};
    end
    ram_rd_en   = cmd.start | cmd.rd_slot;
    // top slot is fetched while the divider runs
    ram_rd_addr = cmd.start ? SW'(top_dec) : SW'(slot);
  end

  assign slot_content = rd_data[SW] ? rd_data[SW-1:0] : SW'(slot);

  always_comb begin
    top_nxt   = repeat_mode ? top_r : top_dec;
    draws_nxt = (draws_r == rpd_pkg::DRAW_SAT) ? draws_r : draws_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      draws_r     <= '0;
      clr_cnt_r   <= '0;
      start_q_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_q_r <= cmd.start;
      if (cmd.clr_restart) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          top_r   <= eff_span;
          draws_r <= '0;
        end
      end
      if (cmd.commit) begin
        top_r   <= top_nxt;
        draws_r <= draws_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_q_r) begin
      top_content_r <= rd_data[SW] ? rd_data[SW-1:0] : SW'(top_dec);
    end
    if (cmd.commit) begin
      out_drawn_r <= base_value + rpd_pkg::DATA_W'(slot_content);
      out_last_r  <= rpd_pkg::limit_hit(head_count, draws_nxt) || (top_nxt == '0);
    end
  end

  assign stat.clr_last = (clr_cnt_r == CLR_LAST);
  assign stat.active   = (top_r != '0) && !rpd_pkg::limit_hit(head_count, draws_r);
  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_drawn_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

### sv/random_permutation_drawer.sv
// random_permutation_drawer: draws numbers from base .. base+span-1, one per input beat.
// input channel: in_valid/in_stall carry a 32-bit random word; output channel:
// out_valid/out_stall carry the drawn number and a last flag on the final draw.
// with repeat off each number of the range comes out once (sparse swap table in a
// MAX_SPAN-entry ram); with repeat on every draw is independent.
// an item runs from accept to result through the bit-per-cycle remainder unit
// (random word mod remaining count), then one ram read of the drawn slot and
// a commit step that writes the swap entry when repeat is off; the next beat
// is taken the cycle after commit, so a beat is never taken while one is in flight.
// once the head count is reached or the range is used up, beats are still taken
// but give no result. the output register holds a finished result while the
// receiver stalls; the next beat is accepted meanwhile and waits at commit.
// reset, and any register write over the apb port, starts a clearing pass over
// all MAX_SPAN entries of the swap table during which in_stall stays high.
// registers: 0 base, 1 span (1..MAX_SPAN, larger 11-bit values saturate), 2 head count
// (17-bit signed, -1 unlimited), 3 repeat; byte address 4*index.
`default_nettype none
module random_permutation_drawer #(
  parameter int MAX_SPAN = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [3:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [rpd_pkg::DATA_W-1:0] in_random_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [rpd_pkg::DATA_W-1:0] out_drawn_value,
  output logic                            out_last
);

  logic [rpd_pkg::DATA_W-1:0] base_r;
  logic [rpd_pkg::TOP_W-1:0]  span_r;
  logic [rpd_pkg::HEAD_W-1:0] head_r;
  logic                       repeat_r;
  logic                       cfg_wr;
  rpd_pkg::reg_idx_t          reg_idx;
  rpd_pkg::cmd_t              cmd;
  rpd_pkg::stat_t             stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = rpd_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      span_r   <= rpd_pkg::TOP_W'(1);
      head_r   <= rpd_pkg::HEAD_UNLIMITED;
      repeat_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rpd_pkg::REG_BASE:   base_r   <= pwdata;
        rpd_pkg::REG_SPAN:   span_r   <= pwdata[rpd_pkg::TOP_W-1:0];
        rpd_pkg::REG_HEAD:   head_r   <= pwdata[rpd_pkg::HEAD_W-1:0];
        rpd_pkg::REG_REPEAT: repeat_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rpd_pkg::REG_BASE:   prdata = base_r;
      rpd_pkg::REG_SPAN:   prdata = 32'(span_r);
      rpd_pkg::REG_HEAD:   prdata = 32'(head_r);
      rpd_pkg::REG_REPEAT: prdata = 32'(repeat_r);
      default:             prdata = '0;
    endcase
  end

  rpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpd_dp #(
    .MAX_SPAN (MAX_SPAN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .base_value      (base_r),
    .span_count      (span_r),
    .head_count      (head_r),
    .repeat_mode     (repeat_r),
    .random_value    (in_random_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drawn_value (out_drawn_value),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire
